>>> rtl/mprm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the multi-pattern response matcher.
// No dependencies; used by the top level and its checker.
package mprm_pkg;

   localparam int NUM_PATTERNS_DEF  = 4;
   localparam int PATTERN_BYTES_DEF = 8;
   localparam int PATTERN_REGS      = 4;
   localparam int PATTERN_MAX_BYTES = 8;

   localparam int PAT_WIDTH      = 64;
   localparam int IDX_WIDTH      = 4;
   localparam int PCOUNT_WIDTH   = 3;
   localparam int TICK_WIDTH     = 32;
   localparam int CNT_WIDTH      = 16;
   localparam int MATCH_WIDTH    = 2;
   localparam int FUNC_WIDTH     = 2;
   localparam int STATUS_WIDTH   = 2;
   localparam int BYTE_WIDTH     = 8;

   localparam int REQ_TDATA_WIDTH = 8;
   localparam int RSP_TDATA_WIDTH = 24;
   localparam int RSP_PAD_WIDTH   = RSP_TDATA_WIDTH - CNT_WIDTH - MATCH_WIDTH;

   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;

   localparam logic [BYTE_WIDTH-1:0]   TERMINATOR          = 8'h00;
   localparam logic [PCOUNT_WIDTH-1:0] PATTERN_COUNT_RESET = 3'd1;
   localparam logic [TICK_WIDTH-1:0]   TIMEOUT_RESET       = 32'd0;
   localparam logic [CNT_WIDTH-1:0]    CAPTURE_LIMIT_RESET = 16'd256;

   // Item kinds on the request channel
   localparam logic [FUNC_WIDTH-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_BYTE  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TICK  = 2'd2;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_SEARCHING = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_TIMEOUT   = 2'd2,
      STATUS_IGNORED   = 2'd3
   } status_type;

   // Register indexes, taken from paddr[5:3]
   localparam logic [2:0] REG_PATTERN_0     = 3'd0;
   localparam logic [2:0] REG_PATTERN_1     = 3'd1;
   localparam logic [2:0] REG_PATTERN_2     = 3'd2;
   localparam logic [2:0] REG_PATTERN_3     = 3'd3;
   localparam logic [2:0] REG_PATTERN_COUNT = 3'd4;
   localparam logic [2:0] REG_TIMEOUT       = 3'd5;
   localparam logic [2:0] REG_CAPTURE_LIMIT = 3'd6;

   // Length of a pattern: bytes before the first terminator, capped at nbytes
   function automatic logic [IDX_WIDTH-1:0] pattern_len(input logic [PAT_WIDTH-1:0] pat,
                                                         input int nbytes);
      logic [IDX_WIDTH-1:0] len;
      logic                 stop;
      len  = '0;
      stop = 1'b0;
      for (int j = 0; j < PATTERN_MAX_BYTES; j++) begin
         if (!stop && j < nbytes && pat[8*j +: 8] != TERMINATOR) begin
            len = IDX_WIDTH'(j + 1);
         end else begin
            stop = 1'b1;
         end
      end
      return len;
   endfunction

endpackage

>>> rtl/multi_pattern_response_matcher_top.sv
`timescale 1ns / 1ps
// Multi-pattern response matcher: byte-stream search for configured strings.
// Depends on mprm_pkg; checked by mprm_checker (bound in its own file).
//
//   channel   dir   handshake               payload
//   req_*     in    tvalid/tready           tuser=func, tdata=rx_byte
//   rsp_*     out   tvalid/tready           tuser=status, tdata=match_index,captured_count
//   csr_*     in    psel/penable/pready     64-bit registers at paddr 8*i
//
// One beat per cycle sustained while results are taken; each beat is held in the input register
// and its result is then registered in the result register.
// All pattern lanes compare the byte in parallel.
// Synchronous reset clears search state and loads register defaults; no clearing pass.
// A stalled result holds the input register; an empty input register still takes a beat.
module multi_pattern_response_matcher_top #(
   parameter int NUM_PATTERNS  = mprm_pkg::NUM_PATTERNS_DEF,
   parameter int PATTERN_BYTES = mprm_pkg::PATTERN_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mprm_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,   // [7:0] rx_byte
   input  logic [mprm_pkg::FUNC_WIDTH-1:0]      req_tuser,   // [1:0] func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mprm_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,   // [1:0] match_index, [17:2] captured_count
   output logic [mprm_pkg::STATUS_WIDTH-1:0]    rsp_tuser,   // [1:0] status
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mprm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mprm_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mprm_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import mprm_pkg::*;

   localparam int NUM_LANES = (NUM_PATTERNS < PATTERN_REGS) ? NUM_PATTERNS : PATTERN_REGS;

   // configuration registers
   logic [PAT_WIDTH-1:0]    pattern_ff [PATTERN_REGS];
   logic [PCOUNT_WIDTH-1:0] pattern_count_ff;
   logic [TICK_WIDTH-1:0]   timeout_ff;
   logic [CNT_WIDTH-1:0]    capture_limit_ff;

   // search state
   logic [IDX_WIDTH-1:0]    partial_ff [NUM_LANES];
   logic [IDX_WIDTH-1:0]    partial_in [NUM_LANES];
   logic [TICK_WIDTH-1:0]   elapsed_ff, elapsed_in;
   logic [CNT_WIDTH-1:0]    byte_count_ff, byte_count_in;
   logic                    searching_ff, searching_in;

   // input register
   logic                    in_valid_ff;
   logic [FUNC_WIDTH-1:0]   in_func_ff;
   logic [BYTE_WIDTH-1:0]   in_byte_ff;

   // result register
   logic                    out_valid_ff;
   status_type              out_status_ff, status_in;
   logic [MATCH_WIDTH-1:0]  out_match_ff, match_in;
   logic [CNT_WIDTH-1:0]    out_count_ff;

   // per-lane compare results
   logic [IDX_WIDTH-1:0]    lane_len  [NUM_LANES];
   logic [IDX_WIDTH-1:0]    lane_next [NUM_LANES];
   logic [NUM_LANES-1:0]    lane_active, lane_done, lane_upd;
   logic                    found;
   logic [MATCH_WIDTH-1:0]  win_index;

   logic                    advance;
   logic [TICK_WIDTH-1:0]   tick_next;
   logic                    timed_out_now;
   logic                    wr_en;
   logic [2:0]              reg_index;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {RSP_PAD_WIDTH'(0), out_count_ff, out_match_ff};

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[5:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // ---------------------------------------------------------------- registers port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_REGS; i++) begin
            pattern_ff[i] <= '0;
         end
         pattern_count_ff <= PATTERN_COUNT_RESET;
         timeout_ff       <= TIMEOUT_RESET;
         capture_limit_ff <= CAPTURE_LIMIT_RESET;
      end else if (wr_en) begin
         unique case (reg_index) inside
            REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
               pattern_ff[reg_index[1:0]] <= csr_pwdata;
            end
            REG_PATTERN_COUNT: pattern_count_ff <= csr_pwdata[PCOUNT_WIDTH-1:0];
            REG_TIMEOUT:       timeout_ff       <= csr_pwdata[TICK_WIDTH-1:0];
            REG_CAPTURE_LIMIT: capture_limit_ff <= csr_pwdata[CNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index) inside
         REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
            csr_prdata = pattern_ff[reg_index[1:0]];
         end
         REG_PATTERN_COUNT: csr_prdata = CSR_DATA_WIDTH'(pattern_count_ff);
         REG_TIMEOUT:       csr_prdata = CSR_DATA_WIDTH'(timeout_ff);
         REG_CAPTURE_LIMIT: csr_prdata = CSR_DATA_WIDTH'(capture_limit_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pattern lanes
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_active[i] = i < int'(pattern_count_ff);
         lane_len[i]    = pattern_len(pattern_ff[i], PATTERN_BYTES);
         // a stored index at or past the length counts as a mismatch
         if (partial_ff[i] < lane_len[i] &&
             pattern_ff[i][{partial_ff[i][2:0], 3'b000} +: 8] == in_byte_ff) begin
            lane_next[i] = partial_ff[i] + 1'b1;
         end else if (lane_len[i] != '0 && pattern_ff[i][7:0] == in_byte_ff) begin
            lane_next[i] = IDX_WIDTH'(1);
         end else begin
            lane_next[i] = '0;
         end
         lane_done[i] = lane_active[i] && (lane_next[i] >= lane_len[i]);
      end
   end

   // lowest completing lane wins; lanes above it keep their index
   always_comb begin
      found     = 1'b0;
      win_index = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_upd[i] = lane_active[i] && !found;
         if (!found && lane_done[i]) begin
            found     = 1'b1;
            win_index = MATCH_WIDTH'(i);
         end
      end
   end

   // ---------------------------------------------------------------- item decode
   assign tick_next     = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign timed_out_now = (timeout_ff != '0) && (elapsed_ff >= timeout_ff);

   always_comb begin
      status_in     = STATUS_SEARCHING;
      match_in      = '0;
      partial_in    = partial_ff;
      elapsed_in    = elapsed_ff;
      byte_count_in = byte_count_ff;
      searching_in  = searching_ff;
      case (in_func_ff)
         FUNC_START: begin
            for (int i = 0; i < NUM_LANES; i++) begin
               partial_in[i] = '0;
            end
            elapsed_in    = '0;
            byte_count_in = '0;
            searching_in  = 1'b1;
         end
         FUNC_BYTE: begin
            if (!searching_ff) begin
               status_in = STATUS_IGNORED;
            end else if (timed_out_now) begin
               // drop the byte, the deadline has already passed
               searching_in = 1'b0;
               status_in    = STATUS_TIMEOUT;
            end else begin
               if (byte_count_ff < capture_limit_ff) begin
                  byte_count_in = byte_count_ff + 1'b1;
               end
               for (int i = 0; i < NUM_LANES; i++) begin
                  if (lane_upd[i]) begin
                     partial_in[i] = lane_next[i];
                  end
               end
               if (found) begin
                  searching_in = 1'b0;
                  status_in    = STATUS_FOUND;
                  match_in     = win_index;
               end
            end
         end
         FUNC_TICK: begin
            if (!searching_ff) begin
               status_in = STATUS_IGNORED;
            end else begin
               elapsed_in = tick_next;
               if (timeout_ff != '0 && tick_next >= timeout_ff) begin
                  searching_in = 1'b0;
                  status_in    = STATUS_TIMEOUT;
               end
            end
         end
         default: status_in = STATUS_IGNORED;
      endcase
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         searching_ff  <= 1'b0;
         elapsed_ff    <= '0;
         byte_count_ff <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            partial_ff[i] <= '0;
         end
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            searching_ff  <= searching_in;
            elapsed_ff    <= elapsed_in;
            byte_count_ff <= byte_count_in;
            partial_ff    <= partial_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata[BYTE_WIDTH-1:0];
      end
      if (advance) begin
         out_status_ff <= status_in;
         out_match_ff  <= match_in;
         out_count_ff  <= byte_count_in;
      end
   end

endmodule

>>> rtl/mprm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the multi-pattern response matcher, and their bind.
// Depends on mprm_pkg; attaches to multi_pattern_response_matcher_top.
module mprm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [mprm_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [mprm_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);
   import mprm_pkg::*;

   // no result straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat straight after reset");

   // a stalled result beat holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // the pattern number is only given with a match
   a_match_only_when_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_FOUND |-> rsp_tdata[MATCH_WIDTH-1:0] == '0)
      else $error("match index set without a match");

   // padding above the captured count stays clear
   a_pad_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_WIDTH-1:CNT_WIDTH+MATCH_WIDTH] == '0)
      else $error("result padding bits set");

endmodule

bind multi_pattern_response_matcher_top mprm_checker u_mprm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> test/multi_pattern_response_matcher_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the multi-pattern response matcher: streams start, byte and tick
// beats, predicts every response in-bench and compares field by field.
// Depends on mprm_pkg and multi_pattern_response_matcher_top.
module multi_pattern_response_matcher_top_test;
   import mprm_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_PHASES  = 9;
   localparam int BEATS_PER_PHASE = 220;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [BYTE_WIDTH-1:0] rx_byte;
   } rx_beat_type;

   typedef struct packed {
      status_type             status;
      logic [MATCH_WIDTH-1:0] match_index;
      logic [CNT_WIDTH-1:0]   captured;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;   // [7:0] rx_byte
   logic [FUNC_WIDTH-1:0]      req_tuser = '0;   // [1:0] func
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;        // [1:0] match_index, [17:2] captured_count
   logic [STATUS_WIDTH-1:0]    rsp_tuser;        // [1:0] status
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   // Register shadow and search state of the predictor
   logic [PAT_WIDTH-1:0]    cfg_pattern [PATTERN_REGS];
   logic [PCOUNT_WIDTH-1:0] cfg_count;
   logic [TICK_WIDTH-1:0]   cfg_timeout;
   logic [CNT_WIDTH-1:0]    cfg_capture;
   logic [IDX_WIDTH-1:0]    lane_index [NUM_PATTERNS_DEF];
   logic [TICK_WIDTH-1:0]   ticks_seen;
   logic [CNT_WIDTH-1:0]    bytes_seen;
   bit                      hunting;

   rx_beat_type      pending_beats [$];
   match_result_type expected_results [$];
   int            error_count = 0;
   int            phase_beats = 0;
   int            tx_gap = 0;
   int            rx_gap = 0;
   bit            idle_on = 1'b1;
   string         reply_words [8] = '{"OK", "ERROR", "CONNECT", "RING", "AAB", "ABAC",
                                      "NO DIAL", "+CSQ:"};

   multi_pattern_response_matcher_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int text_length(input logic [PAT_WIDTH-1:0] pat);
      int n = 0;
      while (n < PATTERN_BYTES_DEF && pat[8*n +: 8] != TERMINATOR) n++;
      return n;
   endfunction

   function automatic logic [PAT_WIDTH-1:0] pack_text(input string s);
      logic [PAT_WIDTH-1:0] v = '0;
      for (int j = 0; j < s.len() && j < PATTERN_BYTES_DEF; j++) v[8*j +: 8] = s[j];
      return v;
   endfunction

   // Advance the search by one beat and return the response it earns
   function automatic match_result_type predict_match(input logic [FUNC_WIDTH-1:0] fn,
                                                      input logic [BYTE_WIDTH-1:0] rx);
      match_result_type     r;
      int                   n_active;
      int                   len;
      logic [IDX_WIDTH-1:0] idx;
      r.status      = STATUS_SEARCHING;
      r.match_index = '0;
      if (fn == FUNC_START) begin
         foreach (lane_index[p]) lane_index[p] = '0;
         ticks_seen = '0;
         bytes_seen = '0;
         hunting    = 1'b1;
      end else if (!(fn == FUNC_BYTE || fn == FUNC_TICK) || !hunting) begin
         r.status = STATUS_IGNORED;
      end else if (fn == FUNC_TICK) begin
         if (ticks_seen != '1) ticks_seen++;
         if (cfg_timeout != 0 && ticks_seen >= cfg_timeout) begin
            hunting  = 1'b0;
            r.status = STATUS_TIMEOUT;
         end
      end else if (cfg_timeout != 0 && ticks_seen >= cfg_timeout) begin
         // timeout raised while searching: drop the byte unconsumed
         hunting  = 1'b0;
         r.status = STATUS_TIMEOUT;
      end else begin
         n_active = (cfg_count > NUM_PATTERNS_DEF) ? NUM_PATTERNS_DEF : cfg_count;
         if (bytes_seen < cfg_capture) bytes_seen++;
         for (int p = 0; p < n_active && hunting; p++) begin
            len = text_length(cfg_pattern[p]);
            idx = lane_index[p];
            if (idx < len && cfg_pattern[p][8*idx +: 8] == rx) idx++;
            else if (len != 0 && cfg_pattern[p][7:0] == rx) idx = IDX_WIDTH'(1);
            else idx = '0;
            lane_index[p] = idx;
            if (idx >= len) begin
               hunting       = 1'b0;
               r.status      = STATUS_FOUND;
               r.match_index = MATCH_WIDTH'(p);
            end
         end
      end
      r.captured = bytes_seen;
      return r;
   endfunction

   function automatic void push_beat(input logic [FUNC_WIDTH-1:0] fn,
                                     input logic [BYTE_WIDTH-1:0] rx);
      pending_beats.push_back('{func: fn, rx_byte: rx});
      phase_beats++;
   endfunction

   // Mostly bytes of the configured patterns, so partial matches build up
   function automatic logic [BYTE_WIDTH-1:0] pick_byte();
      int p = $urandom_range(0, PATTERN_REGS - 1);
      int len = text_length(cfg_pattern[p]);
      if (len == 0 || $urandom_range(0, 3) == 0) return BYTE_WIDTH'($urandom_range(0, 255));
      return cfg_pattern[p][8*$urandom_range(0, len - 1) +: 8];
   endfunction

   function automatic void queue_prefix(input int p);
      int len = text_length(cfg_pattern[p]);
      int k;
      if (len == 0) begin
         push_beat(FUNC_BYTE, pick_byte());
      end else begin
         k = $urandom_range(0, 1) ? len : $urandom_range(1, len);
         for (int j = 0; j < k; j++) push_beat(FUNC_BYTE, cfg_pattern[p][8*j +: 8]);
      end
   endfunction

   task automatic write_register(input logic [2:0] reg_index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_index)
         REG_PATTERN_COUNT: cfg_count   = value[PCOUNT_WIDTH-1:0];
         REG_TIMEOUT:       cfg_timeout = value[TICK_WIDTH-1:0];
         REG_CAPTURE_LIMIT: cfg_capture = value[CNT_WIDTH-1:0];
         default:           cfg_pattern[reg_index[1:0]] = value;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic randomise_config();
      logic [PAT_WIDTH-1:0] pat;
      int                   r;
      for (int p = 0; p < PATTERN_REGS; p++) begin
         r = $urandom_range(0, 9);
         if (r == 0) pat = '0;
         else if (r == 1) pat = '1;
         else if (r == 2) pat = {$urandom, $urandom};
         else pat = pack_text(reply_words[$urandom_range(0, 7)]);
         // junk beyond the terminator must be ignored
         if (r == 3 && pat[63:56] == TERMINATOR) pat[63:56] = BYTE_WIDTH'($urandom);
         write_register(REG_PATTERN_0 + 3'(p), pat);
      end
      r = $urandom_range(0, 9);
      write_register(REG_PATTERN_COUNT, CSR_DATA_WIDTH'(
                     (r < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7)));
      r = $urandom_range(0, 19);
      if (r < 10) write_register(REG_TIMEOUT, '0);
      else if (r < 17) write_register(REG_TIMEOUT, CSR_DATA_WIDTH'($urandom_range(1, 40)));
      else if (r < 19) write_register(REG_TIMEOUT, CSR_DATA_WIDTH'($urandom_range(41, 500)));
      else write_register(REG_TIMEOUT, CSR_DATA_WIDTH'(32'hFFFF_FFFF));
      r = $urandom_range(0, 9);
      if (r < 4) write_register(REG_CAPTURE_LIMIT, CSR_DATA_WIDTH'(256));
      else if (r < 7) write_register(REG_CAPTURE_LIMIT, CSR_DATA_WIDTH'($urandom_range(0, 12)));
      else if (r < 9) write_register(REG_CAPTURE_LIMIT,
                                     CSR_DATA_WIDTH'($urandom_range(0, 65535)));
      else write_register(REG_CAPTURE_LIMIT, CSR_DATA_WIDTH'(16'hFFFF));
   endtask

   // Sender: hold an offered beat until taken, else maybe idle, else offer the next
   always @(posedge clock) begin
      rx_beat_type next_beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(predict_match(req_tuser, req_tdata));
         if (req_tvalid && !req_tready) begin
         end else if (tx_gap != 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(1, 19) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            next_beat = pending_beats.pop_front();
            req_tuser  <= next_beat.func;
            req_tdata  <= next_beat.rx_byte;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: check each accepted response beat against the oldest prediction
   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with nothing expected: status %0d", rsp_tuser);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[1:0] !== want.match_index) begin
                  $error("match_index: expected %0d, got %0d", want.match_index,
                         rsp_tdata[1:0]);
                  error_count++;
               end
               if (rsp_tdata[2 +: CNT_WIDTH] !== want.captured) begin
                  $error("captured_count: expected %0d, got %0d", want.captured,
                         rsp_tdata[2 +: CNT_WIDTH]);
                  error_count++;
               end
            end
         end
         if (rx_gap != 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int  r;
      bit  first_seq;
      foreach (cfg_pattern[p]) cfg_pattern[p] = '0;
      foreach (lane_index[p]) lane_index[p] = '0;
      cfg_count   = PATTERN_COUNT_RESET;
      cfg_timeout = TIMEOUT_RESET;
      cfg_capture = CAPTURE_LIMIT_RESET;
      ticks_seen  = '0;
      bytes_seen  = '0;
      hunting     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Idle beats are ignored; an empty pattern completes on any byte
      push_beat(FUNC_BYTE, "Z");
      push_beat(FUNC_TICK, 8'h00);
      push_beat(FUNC_UNUSED, 8'h5A);
      push_beat(FUNC_START, 8'h00);
      push_beat(FUNC_BYTE, 8'hFF);
      wait_drained();

      // Naive restart misses AAB in AAAB; then a tick timeout
      write_register(REG_PATTERN_0, pack_text("OK"));
      write_register(REG_PATTERN_1, pack_text("ERROR"));
      write_register(REG_PATTERN_2, '1);
      write_register(REG_PATTERN_3, pack_text("AAB") | 64'h0000_4300_0000_0000);
      write_register(REG_PATTERN_COUNT, CSR_DATA_WIDTH'(4));
      write_register(REG_TIMEOUT, CSR_DATA_WIDTH'(3));
      write_register(REG_CAPTURE_LIMIT, '0);
      push_beat(FUNC_START, 8'h00);
      push_beat(FUNC_BYTE, "A");
      push_beat(FUNC_BYTE, "A");
      push_beat(FUNC_BYTE, "A");
      push_beat(FUNC_BYTE, "B");
      push_beat(FUNC_BYTE, "O");
      push_beat(FUNC_BYTE, "K");
      push_beat(FUNC_START, 8'h00);
      repeat (3) push_beat(FUNC_TICK, 8'h00);
      wait_drained();

      // No active pattern; timeout raised mid-search drops the next byte
      write_register(REG_TIMEOUT, '0);
      write_register(REG_PATTERN_COUNT, '0);
      write_register(REG_CAPTURE_LIMIT, CSR_DATA_WIDTH'(16'hFFFF));
      push_beat(FUNC_START, 8'h00);
      push_beat(FUNC_BYTE, 8'h00);
      push_beat(FUNC_TICK, 8'h00);
      push_beat(FUNC_TICK, 8'h00);
      wait_drained();
      write_register(REG_TIMEOUT, CSR_DATA_WIDTH'(2));
      push_beat(FUNC_BYTE, "E");
      wait_drained();

      // Pattern shortened below its stored index mid-search
      write_register(REG_PATTERN_COUNT, CSR_DATA_WIDTH'(7));
      write_register(REG_TIMEOUT, CSR_DATA_WIDTH'(32'hFFFF_FFFF));
      write_register(REG_CAPTURE_LIMIT, CSR_DATA_WIDTH'(1));
      push_beat(FUNC_START, 8'h00);
      push_beat(FUNC_BYTE, "E");
      push_beat(FUNC_BYTE, "R");
      push_beat(FUNC_BYTE, "R");
      wait_drained();
      write_register(REG_PATTERN_1, pack_text("ER"));
      push_beat(FUNC_BYTE, "E");
      push_beat(FUNC_BYTE, "R");
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         randomise_config();
         phase_beats = 0;
         first_seq   = 1'b1;
         while (phase_beats < BEATS_PER_PHASE) begin
            // the first run may carry on the search left from the last phase
            if (!first_seq || $urandom_range(0, 1)) push_beat(FUNC_START, BYTE_WIDTH'($urandom));
            first_seq = 1'b0;
            repeat ($urandom_range(1, 24)) begin
               r = $urandom_range(0, 19);
               if (r < 9) queue_prefix($urandom_range(0, PATTERN_REGS - 1));
               else if (r < 14) push_beat(FUNC_BYTE, pick_byte());
               else if (r < 17) repeat ($urandom_range(1, 8)) push_beat(FUNC_TICK, BYTE_WIDTH'($urandom));
               else if (r < 19) push_beat(FUNC_BYTE, BYTE_WIDTH'($urandom_range(0, 255)));
               else push_beat(FUNC_UNUSED, BYTE_WIDTH'($urandom));
            end
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
